FILE: src/rigf_pkg.sv
// Shared types and constants for the row interior gap fill block.
// Used by the channel interfaces and every module; depends on nothing.
`default_nettype none

package rigf_pkg;

    // Row geometry and band limits
    localparam int ROW_W      = 64;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_BAND   = 16;

    // Configuration channel geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_BAND_TOP     = 3'd2,
        CFG_BAND_BOTTOM  = 3'd3,
        CFG_WINDOW_LEFT  = 3'd4,
        CFG_WINDOW_RIGHT = 3'd5
    } cfg_idx_e;

    // Register reset values
    localparam logic [6:0] RST_IMAGE_WIDTH  = 7'd64;
    localparam logic [7:0] RST_IMAGE_HEIGHT = 8'd64;
    localparam logic [7:0] RST_BAND_TOP     = 8'd0;
    localparam logic [7:0] RST_BAND_BOTTOM  = 8'd0;
    localparam logic [5:0] RST_WINDOW_LEFT  = 6'd0;
    localparam logic [5:0] RST_WINDOW_RIGHT = 6'd63;

    // Current register contents
    typedef struct packed {
        logic [6:0] image_width;
        logic [7:0] image_height;
        logic [7:0] band_top;
        logic [7:0] band_bottom;
        logic [5:0] window_left;
        logic [5:0] window_right;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic             is_summary;
        logic [3:0]       band_row;
        logic [ROW_W-1:0] fill_mask;
        logic [ROW_W-1:0] lid_mask;
        logic [4:0]       band_height;
    } res_t;

    // Up to two results written into the result queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

`default_nettype wire

FILE: src/rigf_row_if.sv
// Input row channel: valid/ready handshake carrying one image row per beat.
// Depends on rigf_pkg.
`default_nettype none

interface rigf_row_if import rigf_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_pixels;
    logic             last_row;

    modport source (output valid, output row_pixels, output last_row, input ready);
    modport sink   (input valid, input row_pixels, input last_row, output ready);
endinterface

`default_nettype wire

FILE: src/rigf_res_if.sv
// Result channel: valid/ready handshake carrying one row result or summary per beat.
// Depends on rigf_pkg.
`default_nettype none

interface rigf_res_if import rigf_pkg::*;;
    logic             valid;
    logic             ready;
    logic             is_summary;
    logic [3:0]       band_row;
    logic [ROW_W-1:0] fill_mask;
    logic [ROW_W-1:0] lid_mask;
    logic [4:0]       band_height;

    modport source (output valid, output is_summary, output band_row, output fill_mask,
                    output lid_mask, output band_height, input ready);
    modport sink   (input valid, input is_summary, input band_row, input fill_mask,
                    input lid_mask, input band_height, output ready);
endinterface

`default_nettype wire

FILE: src/rigf_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying register index and data.
// Depends on rigf_pkg.
`default_nettype none

interface rigf_cfg_if import rigf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/rigf_cfg_regs.sv
// Configuration register file, written through the configuration channel.
// Depends on rigf_pkg and rigf_cfg_if.
`default_nettype none

module rigf_cfg_regs
    import rigf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rigf_cfg_if.sink    cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;
    cfg_t regs_next;
    logic wr_en;

    // Always take a write beat
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    // Decode the register index; unknown indexes are dropped
    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            unique case (cfg.index)
                CFG_IMAGE_WIDTH:  regs_next.image_width  = cfg.data[6:0];
                CFG_IMAGE_HEIGHT: regs_next.image_height = cfg.data[7:0];
                CFG_BAND_TOP:     regs_next.band_top     = cfg.data[7:0];
                CFG_BAND_BOTTOM:  regs_next.band_bottom  = cfg.data[7:0];
                CFG_WINDOW_LEFT:  regs_next.window_left  = cfg.data[5:0];
                CFG_WINDOW_RIGHT: regs_next.window_right = cfg.data[5:0];
                default:          regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.image_width  <= RST_IMAGE_WIDTH;
            regs_reg.image_height <= RST_IMAGE_HEIGHT;
            regs_reg.band_top     <= RST_BAND_TOP;
            regs_reg.band_bottom  <= RST_BAND_BOTTOM;
            regs_reg.window_left  <= RST_WINDOW_LEFT;
            regs_reg.window_right <= RST_WINDOW_RIGHT;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

FILE: src/rigf_row_fill.sv
// Row fill logic: marks blank runs bounded by ink on both sides that lie in the
// column window. Two log-depth prefix scans, one per direction. Depends on rigf_pkg.
`default_nettype none

module rigf_row_fill
    import rigf_pkg::*;
(
    input  wire logic [ROW_W-1:0] px,
    input  wire logic [6:0]       width,
    input  wire logic [5:0]       win_left,
    input  wire logic [5:0]       win_right,
    output      logic [ROW_W-1:0] fill
);

    localparam int LEVELS = $clog2(ROW_W);

    // Prefix scan toward higher columns: out[x] = g[x] | p[x] & out[x-1]
    function automatic logic [ROW_W-1:0] scan_up(input logic [ROW_W-1:0] g_in,
                                                 input logic [ROW_W-1:0] p_in);
        logic [ROW_W-1:0] g;
        logic [ROW_W-1:0] p;
        g = g_in;
        p = p_in;
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            g = g | (p & (g << (1 << lvl)));
            p = p & (p << (1 << lvl));
        end
        return g;
    endfunction

    // Prefix scan toward lower columns: out[x] = g[x] | p[x] & out[x+1]
    function automatic logic [ROW_W-1:0] scan_dn(input logic [ROW_W-1:0] g_in,
                                                 input logic [ROW_W-1:0] p_in);
        logic [ROW_W-1:0] g;
        logic [ROW_W-1:0] p;
        g = g_in;
        p = p_in;
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            g = g | (p & (g >> (1 << lvl)));
            p = p & (p >> (1 << lvl));
        end
        return g;
    endfunction

    logic [6:0]       right_clamp;
    logic [ROW_W-1:0] in_width;
    logic [ROW_W-1:0] in_win;
    logic [ROW_W-1:0] ink;
    logic [ROW_W-1:0] blank_win;
    logic [ROW_W-1:0] from_left;
    logic [ROW_W-1:0] from_right;

    // Clamp the window's right edge to the last column in use
    assign right_clamp = ({1'b0, win_right} >= width) ? (width - 7'd1) : {1'b0, win_right};

    // Per-column width and window masks
    always_comb
    begin
        for (int x = 0; x < ROW_W; x++)
        begin
            in_width[x] = 7'(x) < width;
            in_win[x]   = in_width[x] && (7'(x) >= {1'b0, win_left})
                          && (7'(x) <= right_clamp);
        end
    end

    assign ink       = px & in_width;
    assign blank_win = ~ink & in_win;

    // Blank chain reaches ink on the left, and on the right, without leaving the window
    assign from_left  = scan_up(ink << 1, blank_win << 1);
    assign from_right = scan_dn(ink >> 1, blank_win >> 1);

    assign fill = blank_win & from_left & from_right;

endmodule

`default_nettype wire

FILE: src/rigf_result_fifo.sv
// Four-entry result queue: takes up to two results a cycle, gives one a beat.
// Depends on rigf_pkg and rigf_res_if.
`default_nettype none

module rigf_result_fifo
    import rigf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire push_t  push,
    output      logic   room2,
    rigf_res_if.source  results
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;
    res_t             head;

    assign pop   = results.valid && results.ready;
    assign room2 = count_reg <= CNT_W'(DEPTH - 2);

    // Advance pointers and occupancy
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the first and second results into consecutive entries
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    // Present the oldest entry
    assign head                = entry_reg[rd_ptr_reg];
    assign results.valid       = count_reg != '0;
    assign results.is_summary  = head.is_summary;
    assign results.band_row    = head.band_row;
    assign results.fill_mask   = head.fill_mask;
    assign results.lid_mask    = head.lid_mask;
    assign results.band_height = head.band_height;

endmodule

`default_nettype wire

FILE: src/row_interior_gap_fill.sv
// Top level of the row interior gap fill block: input register, band control,
// row fill and result queue. Depends on rigf_pkg, the channel interfaces,
// rigf_cfg_regs, rigf_row_fill and rigf_result_fifo.
//
//   Channel   Direction  Beat
//   rows      in         one image row: row_pixels, last_row
//   results   out        one row result or one summary
//   cfg       in         one register write: index, data
//
// A row is taken every cycle while the result queue has room; its results pass through
// the input register and then the result queue before they reach the output.
// A last row inside the band yields two results: the row result, then the summary.
// Rows stall only while the four-entry result queue has fewer than two free slots.
// Reset clears the frame state and restores the registers; there is no clearing pass.
`default_nettype none

module row_interior_gap_fill
    import rigf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rigf_row_if.sink    rows,
    rigf_res_if.source  results,
    rigf_cfg_if.sink    cfg
);

    cfg_t             regs;
    logic             room2;
    push_t            push;

    logic             s1_valid_reg;
    logic [ROW_W-1:0] s1_pixels_reg;
    logic             s1_last_reg;
    logic             s1_fire;
    logic             row_take;

    logic [7:0]       row_count_reg;
    logic [7:0]       row_count_next;
    logic [ROW_W-1:0] top_fill_reg;
    logic [ROW_W-1:0] top_fill_next;
    logic             any_filled_reg;
    logic             any_filled_next;

    logic [6:0]       width_use;
    logic             band_valid;
    logic [8:0]       band_span;
    logic [8:0]       band_h;
    logic [8:0]       rel_row;
    logic             in_band;
    logic             is_mid;
    logic [ROW_W-1:0] fill;
    logic             push_row;
    logic             push_sum;
    res_t             row_res;
    res_t             sum_res;

    rigf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Input register: refill when empty or when its row moves on this cycle
    assign s1_fire    = s1_valid_reg && room2;
    assign rows.ready = !s1_valid_reg || s1_fire;
    assign row_take   = rows.valid && rows.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rows.ready)
        begin
            s1_valid_reg <= rows.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_take)
        begin
            s1_pixels_reg <= rows.row_pixels;
            s1_last_reg   <= rows.last_row;
        end
    end

    // Band geometry from the current registers
    always_comb
    begin
        width_use  = (regs.image_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : regs.image_width;
        band_valid = (regs.band_bottom < regs.image_height)
                     && (regs.band_bottom >= regs.band_top);
        band_span  = {1'b0, regs.band_bottom} - {1'b0, regs.band_top} + 9'd1;
        if (!band_valid)
        begin
            band_h = '0;
        end
        else if (band_span > 9'(MAX_BAND))
        begin
            band_h = 9'(MAX_BAND);
        end
        else
        begin
            band_h = band_span;
        end
        rel_row = {1'b0, row_count_reg} - {1'b0, regs.band_top};
        in_band = band_valid && (row_count_reg >= regs.band_top) && (rel_row < band_h);
        is_mid  = (band_h >= 9'd2) && (rel_row == (band_h >> 1));
    end

    rigf_row_fill u_row_fill (
        .px        (s1_pixels_reg),
        .width     (width_use),
        .win_left  (regs.window_left),
        .win_right (regs.window_right),
        .fill      (fill)
    );

    // Build the row result and the summary
    assign push_row        = s1_fire && in_band;
    assign push_sum        = s1_fire && s1_last_reg;
    assign any_filled_next = any_filled_reg || (in_band && (fill != '0));

    always_comb
    begin
        row_res.is_summary  = 1'b0;
        row_res.band_row    = rel_row[3:0];
        row_res.fill_mask   = fill;
        row_res.lid_mask    = is_mid ? top_fill_reg : '0;
        row_res.band_height = '0;

        sum_res.is_summary  = 1'b1;
        sum_res.band_row    = '0;
        sum_res.fill_mask   = '0;
        sum_res.lid_mask    = '0;
        sum_res.band_height = (band_valid && any_filled_next) ? band_h[4:0] : 5'd0;
    end

    // Order the results into the queue: row result first, summary after
    always_comb
    begin
        push.second = sum_res;
        priority if (push_row && push_sum)
        begin
            push.count = 2'd2;
            push.first = row_res;
        end
        else if (push_row)
        begin
            push.count = 2'd1;
            push.first = row_res;
        end
        else if (push_sum)
        begin
            push.count = 2'd1;
            push.first = sum_res;
        end
        else
        begin
            push.count = 2'd0;
            push.first = row_res;
        end
    end

    // Frame state: advance per row, clear after the last row
    always_comb
    begin
        row_count_next = row_count_reg;
        top_fill_next  = top_fill_reg;
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                row_count_next = '0;
                top_fill_next  = '0;
            end
            else
            begin
                if (row_count_reg != 8'd255)
                begin
                    row_count_next = row_count_reg + 8'd1;
                end
                if (in_band && (rel_row == 9'd0))
                begin
                    top_fill_next = fill;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= '0;
            top_fill_reg   <= '0;
            any_filled_reg <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            top_fill_reg  <= top_fill_next;
            if (s1_fire)
            begin
                any_filled_reg <= s1_last_reg ? 1'b0 : any_filled_next;
            end
        end
    end

    rigf_result_fifo u_result_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room2   (room2),
        .results (results)
    );

    // A row result only comes from a valid band
    assert property (@(posedge clk) disable iff (!rst_n)
        push_row |-> band_valid && (rel_row < 9'(MAX_BAND)))
        else $error("row result outside a valid band");

    // The last row leaves the frame state cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> (row_count_reg == '0) && !any_filled_reg
                                   && (top_fill_reg == '0))
        else $error("frame state not cleared after last row");

    // The row counter holds at its ceiling
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_last_reg && (row_count_reg == 8'd255) |=> row_count_reg == 8'd255)
        else $error("row counter wrapped");

    // A lid mask only appears on the middle band row
    assert property (@(posedge clk) disable iff (!rst_n)
        push_row && (row_res.lid_mask != '0) |-> is_mid && (rel_row != 9'd0))
        else $error("lid mask off the middle row");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench for row_interior_gap_fill: a directed table of rows, then random frames over
// many register settings, each result beat checked against the table or a behavioral gap-fill predictor.
// Depends on rigf_pkg and the row, result and config channel interfaces.
`timescale 1ns / 100ps

module tb;
    import rigf_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int MAX_REPORTS   = 40;

    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_e;
    typedef enum int { STEP_ROW, STEP_CFG } step_kind_e;

    // One line of the directed table: a register write or a row
    typedef struct {
        step_kind_e  kind;
        cfg_idx_e    reg_sel;
        logic [7:0]  reg_val;
        logic [63:0] pixels;
        logic        last;
        bit          known;
        bit          has_row;
        logic [63:0] fill;
        bit          has_sum;
        logic [4:0]  height;
    } dir_step_t;

    // One register setting and how many rows to run under it
    typedef struct {
        int width;
        int height;
        int band_top;
        int band_bottom;
        int win_lo;
        int win_hi;
        int budget;
        int frame_len;
        int hold;
    } setting_t;

    logic clk;
    logic rst_n;

    rigf_row_if row_ch ();
    rigf_res_if res_ch ();
    rigf_cfg_if cfg_ch ();

    row_interior_gap_fill u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .rows    (row_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    // Predictor copy of the registers and the frame state
    cfg_t        shadow;
    logic [7:0]  frame_row;
    logic [63:0] frame_top_fill;
    bit          frame_any_fill;

    res_t        pending_beats[$];
    res_t        known_beats[$];
    bit          known_armed;

    idle_mode_e  idle_mode;
    int          hold_left;
    int          cycles = 0;
    int          errors = 0;
    int          rows_sent = 0;
    int          beats_checked = 0;
    int          fills_seen = 0;
    int          lids_seen = 0;
    int          heights_seen = 0;
    int          settings_run = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d beats still expected", cycles,
                     pending_beats.size());
            $display("FAIL row_interior_gap_fill");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch %s: got %h expected %h (beat %0d, t=%0t)", what, got, want,
                     beats_checked, $time);
    endtask

    function automatic logic [63:0] ones_below(int n);
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // Fill each blank run bounded by ink on both sides that lies inside the window
    function automatic logic [63:0] gap_fill(logic [63:0] px, int span, int win_lo, int win_hi);
        logic [63:0] filled;
        int          first_ink;
        int          last_ink;
        int          run_start;
        bit          in_gap;
        filled    = '0;
        first_ink = -1;
        last_ink  = 0;
        run_start = 0;
        in_gap    = 1'b0;
        if (span == 0)
            return '0;
        if (win_hi >= span)
            win_hi = span - 1;
        px &= ones_below(span);
        for (int x = 0; x < span; x++)
        begin
            if (px[x])
            begin
                if (first_ink < 0)
                    first_ink = x;
                last_ink = x;
            end
        end
        if (first_ink < 0)
            return '0;
        for (int x = first_ink; x <= last_ink; x++)
        begin
            if (!px[x] && !in_gap)
            begin
                in_gap    = 1'b1;
                run_start = x;
            end
            if (px[x] && in_gap)
            begin
                in_gap = 1'b0;
                if (run_start >= win_lo && x - 1 <= win_hi)
                    filled |= ones_below(x) & ~ones_below(run_start);
            end
        end
        return filled;
    endfunction

    function automatic int active_span();
        return (shadow.image_width > 7'd64) ? 64 : int'(shadow.image_width);
    endfunction

    // Advance the frame state by one row and collect the beats it causes
    task automatic advance_frame(input logic [63:0] px, input logic last, ref res_t beats[$]);
        int          b_top;
        int          b_bot;
        int          b_height;
        int          row_idx;
        int          rel;
        bit          band_ok;
        logic [63:0] fill;
        res_t        beat;
        b_top    = shadow.band_top;
        b_bot    = shadow.band_bottom;
        band_ok  = b_bot < int'(shadow.image_height) && b_bot >= b_top;
        b_height = 0;
        row_idx  = frame_row;
        if (band_ok)
            b_height = (b_bot - b_top + 1 > MAX_BAND) ? MAX_BAND : b_bot - b_top + 1;
        if (band_ok && row_idx >= b_top && row_idx < b_top + b_height)
        begin
            rel  = row_idx - b_top;
            fill = gap_fill(px, active_span(), shadow.window_left, shadow.window_right);
            if (rel == 0)
                frame_top_fill = fill;
            if (fill != '0)
                frame_any_fill = 1'b1;
            beat           = '0;
            beat.band_row  = rel[3:0];
            beat.fill_mask = fill;
            beat.lid_mask  = (b_height >= 2 && rel == b_height / 2) ? frame_top_fill : '0;
            beats.push_back(beat);
        end
        if (frame_row != 8'd255)
            frame_row++;
        if (last)
        begin
            beat             = '0;
            beat.is_summary  = 1'b1;
            beat.band_height = (band_ok && frame_any_fill) ? b_height[4:0] : 5'd0;
            beats.push_back(beat);
            frame_row      = '0;
            frame_top_fill = '0;
            frame_any_fill = 1'b0;
        end
    endtask

    function automatic int stall_pct(bit sender_side);
        case (idle_mode)
            IDLE_SENDER:   return sender_side ? 68 : 0;
            IDLE_RECEIVER: return sender_side ? 0 : 68;
            IDLE_BOTH:     return 12;
            default:       return 0;
        endcase
    endfunction

    // Offer one row beat and record what it should produce; starts and ends at a falling edge
    task automatic send_row(input logic [63:0] px, input logic last);
        res_t beats[$];
        while ($urandom_range(99) < stall_pct(1'b1))
        begin
            row_ch.valid <= 1'b0;
            @(negedge clk);
        end
        row_ch.valid      <= 1'b1;
        row_ch.row_pixels <= px;
        row_ch.last_row   <= last;
        do
            @(posedge clk);
        while (!row_ch.ready);
        advance_frame(px, last, beats);
        if (known_armed)
        begin
            beats = known_beats;
            known_beats.delete();
            known_armed = 1'b0;
        end
        foreach (beats[i])
            pending_beats.push_back(beats[i]);
        rows_sent++;
        @(negedge clk);
    endtask

    // Hold the row channel until every expected beat is back, then let the pipe settle
    task automatic drain_results();
        row_ch.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_e sel, input logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= sel;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (sel)
            CFG_IMAGE_WIDTH:  shadow.image_width  = val[6:0];
            CFG_IMAGE_HEIGHT: shadow.image_height = val;
            CFG_BAND_TOP:     shadow.band_top     = val;
            CFG_BAND_BOTTOM:  shadow.band_bottom  = val;
            CFG_WINDOW_LEFT:  shadow.window_left  = val[5:0];
            CFG_WINDOW_RIGHT: shadow.window_right = val[5:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Random row: blank, solid, noise, sparse, dense, or a bounded gap with scattered ink
    function automatic logic [63:0] pick_pixels(int span);
        logic [63:0] px;
        int          top_col;
        int          lo;
        int          hi;
        px      = {$urandom, $urandom};
        top_col = (span >= 2 && span < 64 && $urandom_range(9) < 7) ? span - 1 : 63;
        case ($urandom_range(9))
            0: px = '0;
            1: px = '1;
            2: ;
            3: px = px & {$urandom, $urandom} & {$urandom, $urandom};
            4: px = px | {$urandom, $urandom};
            default:
            begin
                lo = $urandom_range(top_col - 1, 0);
                hi = $urandom_range(top_col, lo + 1);
                for (int x = lo; x <= hi; x++)
                    px[x] = ($urandom_range(7) == 0);
                px[lo] = 1'b1;
                px[hi] = 1'b1;
            end
        endcase
        return px;
    endfunction

    function automatic setting_t mk_setting(int w, int h, int t, int b, int lo, int hi,
                                            int budget, int frame_len, int hold);
        setting_t s;
        s.width       = w;
        s.height      = h;
        s.band_top    = t;
        s.band_bottom = b;
        s.win_lo      = lo;
        s.win_hi      = hi;
        s.budget      = budget;
        s.frame_len   = frame_len;
        s.hold        = hold;
        return s;
    endfunction

    function automatic dir_step_t dir_cfg(cfg_idx_e sel, logic [7:0] val);
        dir_step_t d;
        d.kind    = STEP_CFG;
        d.reg_sel = sel;
        d.reg_val = val;
        d.pixels  = '0;
        d.last    = 1'b0;
        d.known   = 1'b0;
        d.has_row = 1'b0;
        d.fill    = '0;
        d.has_sum = 1'b0;
        d.height  = '0;
        return d;
    endfunction

    function automatic dir_step_t dir_row(logic [63:0] px, logic last);
        dir_step_t d;
        d        = dir_cfg(CFG_IMAGE_WIDTH, 8'd0);
        d.kind   = STEP_ROW;
        d.pixels = px;
        d.last   = last;
        return d;
    endfunction

    // Row whose beats are read straight off the spec; band row 0 and no lid in all of them
    function automatic dir_step_t dir_known(logic [63:0] px, logic last, bit has_row,
                                            logic [63:0] fill, bit has_sum, logic [4:0] height);
        dir_step_t d;
        d         = dir_row(px, last);
        d.known   = 1'b1;
        d.has_row = has_row;
        d.fill    = fill;
        d.has_sum = has_sum;
        d.height  = height;
        return d;
    endfunction

    // Write one setting, then run whole frames under it
    task automatic run_setting(input setting_t s, input idle_mode_e mode);
        int sent;
        int frame_len;
        drain_results();
        write_reg(CFG_IMAGE_WIDTH, s.width[7:0]);
        write_reg(CFG_IMAGE_HEIGHT, s.height[7:0]);
        write_reg(CFG_BAND_TOP, s.band_top[7:0]);
        write_reg(CFG_BAND_BOTTOM, s.band_bottom[7:0]);
        write_reg(CFG_WINDOW_LEFT, s.win_lo[7:0]);
        write_reg(CFG_WINDOW_RIGHT, s.win_hi[7:0]);
        idle_mode = mode;
        if (s.hold > 0)
        begin
            @(posedge clk);
            hold_left = s.hold;
            @(negedge clk);
        end
        sent = 0;
        while (sent < s.budget)
        begin
            if (s.frame_len > 0)
                frame_len = s.frame_len;
            else if ($urandom_range(99) < 15)
                frame_len = $urandom_range(s.height + 8, 1);
            else
                frame_len = s.height;
            for (int k = 0; k < frame_len; k++)
                send_row(pick_pixels(active_span()), k == frame_len - 1);
            sent += frame_len;
        end
        settings_run++;
    endtask

    // Receiver: long hold-off when asked, else random stalls per idle mode
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= stall_pct(1'b0));
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_beats.size() == 0)
                report_mismatch("unexpected beat fill_mask", res_ch.fill_mask, '0);
            else
            begin
                want = pending_beats.pop_front();
                if (res_ch.is_summary !== want.is_summary)
                    report_mismatch("is_summary", res_ch.is_summary, want.is_summary);
                if (res_ch.band_row !== want.band_row)
                    report_mismatch("band_row", res_ch.band_row, want.band_row);
                if (res_ch.fill_mask !== want.fill_mask)
                    report_mismatch("fill_mask", res_ch.fill_mask, want.fill_mask);
                if (res_ch.lid_mask !== want.lid_mask)
                    report_mismatch("lid_mask", res_ch.lid_mask, want.lid_mask);
                if (res_ch.band_height !== want.band_height)
                    report_mismatch("band_height", res_ch.band_height, want.band_height);
                beats_checked++;
                if (want.fill_mask != '0)
                    fills_seen++;
                if (want.lid_mask != '0)
                    lids_seen++;
                if (want.band_height != '0)
                    heights_seen++;
            end
        end
    end

    // Main sequence
    initial
    begin
        dir_step_t directed[$];
        setting_t  plan[$];
        res_t      beat;
        int        h;
        int        t;
        int        b;
        int        w;
        int        lo;
        int        hi;

        rst_n             = 1'b0;
        row_ch.valid      = 1'b0;
        row_ch.row_pixels = '0;
        row_ch.last_row   = 1'b0;
        res_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_IMAGE_WIDTH;
        cfg_ch.data       = '0;
        idle_mode         = IDLE_NONE;
        hold_left         = 0;
        known_armed       = 1'b0;
        shadow.image_width  = RST_IMAGE_WIDTH;
        shadow.image_height = RST_IMAGE_HEIGHT;
        shadow.band_top     = RST_BAND_TOP;
        shadow.band_bottom  = RST_BAND_BOTTOM;
        shadow.window_left  = RST_WINDOW_LEFT;
        shadow.window_right = RST_WINDOW_RIGHT;
        frame_row      = '0;
        frame_top_fill = '0;
        frame_any_fill = 1'b0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset values: band is image row 0 only, full width and window
        directed.push_back(dir_known(64'h0, 1'b0, 1'b1, 64'h0, 1'b0, 5'd0));
        directed.push_back(dir_known('1, 1'b1, 1'b0, 64'h0, 1'b1, 5'd0));
        directed.push_back(dir_known(64'h8000_0000_0000_0001, 1'b1,
                                     1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 5'd1));
        directed.push_back(dir_known(64'h5555_5555_5555_5555, 1'b0,
                                     1'b1, 64'h2AAA_AAAA_AAAA_AAAA, 1'b0, 5'd0));
        directed.push_back(dir_known(64'h0, 1'b1, 1'b0, 64'h0, 1'b1, 5'd1));
        // Run ends one column past the window edge: no fill
        directed.push_back(dir_cfg(CFG_WINDOW_RIGHT, 8'd61));
        directed.push_back(dir_known(64'h8000_0000_0000_0001, 1'b1,
                                     1'b1, 64'h0, 1'b1, 5'd0));
        // Zero width: nothing in use
        directed.push_back(dir_cfg(CFG_IMAGE_WIDTH, 8'd0));
        directed.push_back(dir_known(64'h8000_0000_0000_0001, 1'b1,
                                     1'b1, 64'h0, 1'b1, 5'd0));
        // Width above the maximum clamps to full row
        directed.push_back(dir_cfg(CFG_IMAGE_WIDTH, 8'd127));
        directed.push_back(dir_cfg(CFG_WINDOW_RIGHT, 8'd63));
        directed.push_back(dir_known(64'h8000_0000_0000_0001, 1'b1,
                                     1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 5'd1));
        // Narrow width: upper bits ignored, window clamped to width
        directed.push_back(dir_cfg(CFG_IMAGE_WIDTH, 8'd8));
        directed.push_back(dir_known(64'hFFFF_FFFF_FFFF_FF81, 1'b1,
                                     1'b1, 64'h7E, 1'b1, 5'd1));
        // Five-row band: lid on band row 2
        directed.push_back(dir_cfg(CFG_IMAGE_WIDTH, 8'd64));
        directed.push_back(dir_cfg(CFG_IMAGE_HEIGHT, 8'd5));
        directed.push_back(dir_cfg(CFG_BAND_BOTTOM, 8'd4));
        directed.push_back(dir_row(64'h8000_0000_0000_0001, 1'b0));
        directed.push_back(dir_row(64'h0000_FF00_00FF_0000, 1'b0));
        directed.push_back(dir_row(64'h0F0F_0F0F_0F0F_0F0F, 1'b0));
        directed.push_back(dir_row(64'h0000_0000_0000_0001, 1'b0));
        directed.push_back(dir_row(64'hC000_0000_0000_0003, 1'b1));
        // Band bottom at the image height: invalid band, summary only
        directed.push_back(dir_cfg(CFG_IMAGE_HEIGHT, 8'd4));
        directed.push_back(dir_known(64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0, 1'b0, 5'd0));
        directed.push_back(dir_known(64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0, 1'b0, 5'd0));
        directed.push_back(dir_known(64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0, 1'b0, 5'd0));
        directed.push_back(dir_known(64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0, 1'b1, 5'd0));
        // Bottom above top: invalid band
        directed.push_back(dir_cfg(CFG_IMAGE_HEIGHT, 8'd8));
        directed.push_back(dir_cfg(CFG_BAND_TOP, 8'd5));
        directed.push_back(dir_cfg(CFG_BAND_BOTTOM, 8'd3));
        directed.push_back(dir_known(64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0, 1'b1, 5'd0));
        // All-ones image height, band top and band bottom
        directed.push_back(dir_cfg(CFG_IMAGE_HEIGHT, 8'd255));
        directed.push_back(dir_cfg(CFG_BAND_TOP, 8'd255));
        directed.push_back(dir_cfg(CFG_BAND_BOTTOM, 8'd255));
        directed.push_back(dir_known(64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0, 1'b1, 5'd0));

        // Walk the directed table
        foreach (directed[i])
        begin
            if (directed[i].kind == STEP_CFG)
            begin
                drain_results();
                write_reg(directed[i].reg_sel, directed[i].reg_val);
            end
            else
            begin
                if (directed[i].known)
                begin
                    if (directed[i].has_row)
                    begin
                        beat           = '0;
                        beat.fill_mask = directed[i].fill;
                        known_beats.push_back(beat);
                    end
                    if (directed[i].has_sum)
                    begin
                        beat             = '0;
                        beat.is_summary  = 1'b1;
                        beat.band_height = directed[i].height;
                        known_beats.push_back(beat);
                    end
                    known_armed = 1'b1;
                end
                send_row(directed[i].pixels, directed[i].last);
            end
        end

        // Fixed settings: full band with receiver hold-off, tall band clamp, extremes
        plan.push_back(mk_setting(64, 16, 0, 15, 0, 63, 90, 0, 120));
        plan.push_back(mk_setting(64, 40, 2, 30, 0, 63, 90, 0, 0));
        plan.push_back(mk_setting(1, 3, 0, 2, 0, 0, 60, 0, 0));
        plan.push_back(mk_setting(64, 255, 254, 254, 0, 63, 300, 300, 0));
        plan.push_back(mk_setting(127, 20, 3, 8, 10, 50, 90, 0, 0));
        plan.push_back(mk_setting(0, 10, 0, 9, 0, 63, 60, 0, 0));
        plan.push_back(mk_setting(33, 12, 5, 5, 5, 20, 90, 0, 0));
        plan.push_back(mk_setting(20, 12, 0, 11, 2, 63, 90, 0, 0));
        plan.push_back(mk_setting(64, 8, 6, 2, 0, 63, 60, 0, 0));
        plan.push_back(mk_setting(64, 8, 0, 8, 0, 63, 60, 0, 0));
        plan.push_back(mk_setting(64, 1, 0, 0, 63, 0, 60, 0, 0));
        plan.push_back(mk_setting(64, 3, 0, 1, 0, 63, 90, 0, 0));
        // Random settings, mostly valid small bands
        for (int i = 0; i < 8; i++)
        begin
            h  = $urandom_range(40, 1);
            t  = $urandom_range(h - 1, 0);
            b  = t + $urandom_range(20, 0);
            if ($urandom_range(9) >= 8)
                b = $urandom_range(254, 0);
            w  = ($urandom_range(9) < 7) ? 64 : $urandom_range(64, 1);
            lo = ($urandom_range(9) < 6) ? 0 : $urandom_range(40, 0);
            hi = ($urandom_range(9) < 6) ? 63 : $urandom_range(63, lo);
            plan.push_back(mk_setting(w, h, t, b, lo, hi, 90, 0, 0));
        end

        foreach (plan[i])
            run_setting(plan[i], idle_mode_e'(i % 4));

        drain_results();
        if (pending_beats.size() != 0)
            report_mismatch("beats never returned", pending_beats.size(), 0);

        $display("ran %0d rows under %0d settings plus the directed table; %0d beats checked",
                 rows_sent, settings_run, beats_checked);
        $display("saw %0d filled rows, %0d lid rows, %0d nonzero band summaries",
                 fills_seen, lids_seen, heights_seen);
        if (errors == 0)
            $display("PASS row_interior_gap_fill");
        else
            $display("FAIL row_interior_gap_fill");
        $finish;
    end

endmodule
